// ===== sv/qba_pkg.sv =====
package qba_pkg;

   // Field widths
   localparam int COORD_W = 32;
   localparam int DIR_W = 16;
   localparam int COUNT_W = 7;
   localparam int INDEX_W = 6;
   localparam int MAX_POINTS = 64;

   // Curve parameter t, unsigned with 16 fraction bits
   localparam int T_W = 17;
   localparam int T_ONE = 65536;

   // Shared iterative units
   localparam int SQRT_IN_W = 60;
   localparam int SQRT_OUT_W = 30;
   localparam int DIV_N_W = 61;
   localparam int DIV_D_W = 30;
   localparam int DIV_Q_W = 31;

   // Multiplier and accumulator
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 33;
   localparam int PROD_W = MUL_A_W + MUL_B_W;
   localparam int ACC_W = 68;
   localparam int WGT_W = 33;

   // Stream beat widths
   localparam int REQ_W = 280;
   localparam int RSP_W = 104;

   // Clamp a wide signed value to the coordinate range
   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = {{(ACC_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
      lo = ~hi;
      if (v > hi) begin
         sat_coord = hi[COORD_W-1:0];
      end else if (v < lo) begin
         sat_coord = lo[COORD_W-1:0];
      end else begin
         sat_coord = v[COORD_W-1:0];
      end
   endfunction

endpackage

// ===== sv/qba_isqrt.sv =====
module qba_isqrt (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [qba_pkg::SQRT_IN_W-1:0]     radicand,
   output logic                              busy,
   output logic                              done,
   output logic [qba_pkg::SQRT_OUT_W-1:0]    root
);
   import qba_pkg::*;

   logic [SQRT_IN_W:0] rem_ff, rem_in;
   logic [SQRT_IN_W:0] res_ff, res_in;
   logic [SQRT_IN_W:0] bit_ff, bit_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [SQRT_IN_W:0] trial;

   assign trial = res_ff + bit_ff;

   // One result bit per cycle, bit walks down by powers of four
   always_comb begin
      rem_in = rem_ff;
      res_in = res_ff;
      bit_in = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = {1'b0, radicand};
         res_in = '0;
         bit_in = (SQRT_IN_W+1)'(1) << (SQRT_IN_W - 2);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign root = res_ff[SQRT_OUT_W-1:0];

endmodule

// ===== sv/qba_div.sv =====
module qba_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [qba_pkg::DIV_N_W-1:0]    numer,
   input  logic [qba_pkg::DIV_D_W-1:0]    denom,
   output logic                           busy,
   output logic                           done,
   output logic [qba_pkg::DIV_Q_W-1:0]    quo,
   output logic [qba_pkg::DIV_N_W-1:0]    rem
);
   import qba_pkg::*;

   logic [DIV_N_W-1:0] rem_ff, rem_in;
   logic [DIV_N_W-1:0] dsh_ff, dsh_in;
   logic [DIV_Q_W-1:0] quo_ff, quo_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic               ge;

   assign ge = rem_ff >= dsh_ff;

   // Restoring division, one quotient bit per cycle, MSB first
   always_comb begin
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = numer;
         dsh_in = DIV_N_W'(denom) << (DIV_Q_W - 1);
         quo_in = '0;
         cnt_in = 5'(DIV_Q_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = rem_ff - dsh_ff;
         end
         quo_in = {quo_ff[DIV_Q_W-2:0], ge};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quo = quo_ff;
   assign rem = rem_ff;

endmodule

// ===== sv/quadratic_bezier_arc_points.sv =====
// Quadratic Bezier arc tessellator.
// The req_ channel takes one arc request per beat: start and end points, bend
// height, bend direction and point count. The rsp_ channel returns one beat
// per curve point, point_index counting up from zero, rsp_tlast on the final
// point. A count below two returns no beats; counts above 64 are clamped.
// The control point is the midpoint plus the normalized bend direction times
// the height; a direction within one LSB of zero means straight up.
// req_tready is high only while no request is in work. Setup computes the
// squared length, a 30-step square root and three 31-step divides for the unit
// vector (all skipped for a direction near zero), then the control point and a
// 31-step divide for the t step. Each point then runs on the single shared
// multiplier (three weights and nine products, each multiply followed by a
// store or an accumulate).
// Results go out through an output register: the next point is computed
// while the previous one waits, and the sequencer holds when rsp_tready is
// low with a point already pending.
// Reset clears the sequencer and the output valid; no beat is pending after it.
module quadratic_bezier_arc_points (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // start_x, start_y, start_z, end_x, end_y, end_z, bend_height,
   // bend_dir_x, bend_dir_y, bend_dir_z, point_count, zero pad
   input  logic [qba_pkg::REQ_W-1:0]     req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // point_x, point_y, point_z, point_index, zero pad
   output logic [qba_pkg::RSP_W-1:0]     rsp_tdata,
   output logic                          rsp_tlast
);
   import qba_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_LEN  = 9'b000000010,
      ST_SQRT = 9'b000000100,
      ST_UDIV = 9'b000001000,
      ST_CTRL = 9'b000010000,
      ST_TDIV = 9'b000100000,
      ST_WGT  = 9'b001000000,
      ST_PNT  = 9'b010000000,
      ST_EMIT = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic signed [COORD_W-1:0] s_ff [3];
   logic signed [COORD_W-1:0] s_in [3];
   logic signed [COORD_W-1:0] e_ff [3];
   logic signed [COORD_W-1:0] e_in [3];
   logic signed [COORD_W-1:0] m_ff [3];
   logic signed [COORD_W-1:0] m_in [3];
   logic signed [COORD_W-1:0] u_ff [3];
   logic signed [COORD_W-1:0] u_in [3];
   logic signed [COORD_W-1:0] p_ff [3];
   logic signed [COORD_W-1:0] p_in [3];
   logic signed [DIR_W-1:0]   d_ff [3];
   logic signed [DIR_W-1:0]   d_in [3];
   logic [WGT_W-1:0]          w_ff [3];
   logic [WGT_W-1:0]          w_in [3];
   logic signed [COORD_W-1:0] h_ff, h_in;
   logic [INDEX_W-1:0]        nm1_ff, nm1_in;
   logic [INDEX_W-1:0]        i_ff, i_in;
   logic [1:0]                k_ff, k_in;
   logic [1:0]                j_ff, j_in;
   logic                      sub_ff, sub_in;
   logic [32:0]               len_ff, len_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic [T_W-1:0]            t_ff, t_in;
   logic [T_W-1:0]            q0_ff, q0_in;
   logic [7:0]                r_ff, r_in;
   logic [COUNT_W-1:0]        r0_ff, r0_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]          rsp_data_ff, rsp_data_in;
   logic                      rsp_last_ff, rsp_last_in;

   // Request fields
   logic [COUNT_W-1:0]        req_count;
   logic [COUNT_W-1:0]        count_sat;
   logic signed [DIR_W-1:0]   req_dir [3];
   logic                      tiny;
   logic                      req_fire;

   // Shared multiplier operands
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic [T_W-1:0]            s_t;

   // Iterative units
   logic                      sqrt_start, sqrt_busy, sqrt_done;
   logic [SQRT_IN_W-1:0]      sqrt_x;
   logic [SQRT_OUT_W-1:0]     sqrt_root;
   logic                      div_start, div_busy, div_done;
   logic [DIV_N_W-1:0]        div_num;
   logic [DIV_D_W-1:0]        div_den;
   logic [DIV_Q_W-1:0]        div_quo;
   logic [DIV_N_W-1:0]        div_rem;

   // Datapath helpers
   logic [32:0]               len_sum;
   logic [DIR_W:0]            dir_abs;
   logic [COORD_W-1:0]        quo_ext;
   logic signed [COORD_W:0]   se_sum;
   logic signed [ACC_W-1:0]   ctrl_acc;
   logic signed [ACC_W-1:0]   pnt_sum;
   logic signed [ACC_W-1:0]   pnt_acc;
   logic [7:0]                r_next;
   logic [7:0]                den2;
   logic                      out_free;
   logic                      last_pt;

   assign req_count = req_tdata[278:272];
   assign req_dir[0] = req_tdata[239:224];
   assign req_dir[1] = req_tdata[255:240];
   assign req_dir[2] = req_tdata[271:256];
   assign count_sat = (req_count > COUNT_W'(MAX_POINTS)) ? COUNT_W'(MAX_POINTS) : req_count;
   assign req_fire = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // Direction within one LSB of zero on every axis
   always_comb begin
      tiny = 1'b1;
      for (int n = 0; n < 3; n++) begin
         if (req_dir[n] > 16'sd1 || req_dir[n] < -16'sd1) begin
            tiny = 1'b0;
         end
      end
   end

   assign s_t = T_W'(T_ONE) - t_ff;

   // Select multiplier operands by sequencer step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_LEN: begin
            mul_a = MUL_A_W'(d_ff[k_ff]);
            mul_b = MUL_B_W'(d_ff[k_ff]);
         end
         ST_CTRL: begin
            mul_a = MUL_A_W'(u_ff[k_ff]);
            mul_b = MUL_B_W'(h_ff);
         end
         ST_WGT: begin
            case (j_ff)
               2'd0: begin
                  mul_a = $signed({{(MUL_A_W-T_W){1'b0}}, s_t});
                  mul_b = $signed({{(MUL_B_W-T_W){1'b0}}, s_t});
               end
               2'd1: begin
                  mul_a = $signed({{(MUL_A_W-T_W){1'b0}}, s_t});
                  mul_b = $signed({{(MUL_B_W-T_W){1'b0}}, t_ff});
               end
               default: begin
                  mul_a = $signed({{(MUL_A_W-T_W){1'b0}}, t_ff});
                  mul_b = $signed({{(MUL_B_W-T_W){1'b0}}, t_ff});
               end
            endcase
         end
         ST_PNT: begin
            mul_a = $signed({1'b0, w_ff[j_ff]});
            case (j_ff)
               2'd0:    mul_b = MUL_B_W'(s_ff[k_ff]);
               2'd1:    mul_b = MUL_B_W'(m_ff[k_ff]);
               default: mul_b = MUL_B_W'(e_ff[k_ff]);
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = $signed({{(PROD_W-MUL_A_W){mul_a[MUL_A_W-1]}}, mul_a})
                  * $signed({{(PROD_W-MUL_B_W){mul_b[MUL_B_W-1]}}, mul_b});

   // Arithmetic around the product register
   assign len_sum = ((k_ff == 2'd0) ? 33'd0 : len_ff) + prod_ff[32:0];
   assign dir_abs = d_ff[k_ff][DIR_W-1] ? ((DIR_W+1)'(0) - {d_ff[k_ff][DIR_W-1], d_ff[k_ff]})
                                        : {d_ff[k_ff][DIR_W-1], d_ff[k_ff]};
   assign quo_ext = {1'b0, div_quo};
   assign se_sum = $signed({s_ff[k_ff][COORD_W-1], s_ff[k_ff]})
                 + $signed({e_ff[k_ff][COORD_W-1], e_ff[k_ff]});
   assign ctrl_acc = ($signed({{(ACC_W-COORD_W-1){se_sum[COORD_W]}}, se_sum}) <<< 29)
                   + $signed({prod_ff[PROD_W-1], prod_ff})
                   + $signed({{(ACC_W-30){1'b0}}, 1'b1, 29'd0});
   assign pnt_sum = ((j_ff == 2'd0) ? {ACC_W{1'b0}} : acc_ff)
                  + $signed({prod_ff[PROD_W-1], prod_ff});
   assign pnt_acc = pnt_sum + $signed({{(ACC_W-32){1'b0}}, 1'b1, 31'd0});
   assign den2 = {1'b0, nm1_ff, 1'b0};
   assign r_next = r_ff + {1'b0, r0_ff};
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign last_pt = (i_ff == nm1_ff);

   assign sqrt_start = (state_ff == ST_LEN) && sub_ff && (k_ff == 2'd2);
   assign sqrt_x = SQRT_IN_W'(len_sum) << 28;
   assign div_start = ((state_ff == ST_UDIV) || (state_ff == ST_TDIV)) && !sub_ff;
   assign div_num = (state_ff == ST_TDIV) ? DIV_N_W'(2 * T_ONE)
                  : ((DIV_N_W'(dir_abs) << 44) + DIV_N_W'(sqrt_root >> 1));
   assign div_den = (state_ff == ST_TDIV) ? DIV_D_W'(den2) : sqrt_root;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      s_in = s_ff;
      e_in = e_ff;
      m_in = m_ff;
      u_in = u_ff;
      p_in = p_ff;
      d_in = d_ff;
      w_in = w_ff;
      h_in = h_ff;
      nm1_in = nm1_ff;
      i_in = i_ff;
      k_in = k_ff;
      j_in = j_ff;
      sub_in = sub_ff;
      len_in = len_ff;
      acc_in = acc_ff;
      t_in = t_ff;
      q0_in = q0_ff;
      r_in = r_ff;
      r0_in = r0_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            // Latch a request; short counts leave no work
            if (req_fire && count_sat >= COUNT_W'(2)) begin
               for (int n = 0; n < 3; n++) begin
                  s_in[n] = req_tdata[32*n +: 32];
                  e_in[n] = req_tdata[96 + 32*n +: 32];
                  d_in[n] = req_dir[n];
               end
               h_in = req_tdata[223:192];
               nm1_in = INDEX_W'(count_sat - COUNT_W'(1));
               k_in = 2'd0;
               sub_in = 1'b0;
               if (tiny) begin
                  u_in[0] = '0;
                  u_in[1] = '0;
                  u_in[2] = COORD_W'(1) << 30;
                  state_in = ST_CTRL;
               end else begin
                  state_in = ST_LEN;
               end
            end
         end
         ST_LEN: begin
            // Sum of squared direction components
            if (!sub_ff) begin
               sub_in = 1'b1;
            end else begin
               len_in = len_sum;
               sub_in = 1'b0;
               if (k_ff == 2'd2) begin
                  state_in = ST_SQRT;
               end else begin
                  k_in = k_ff + 2'd1;
               end
            end
         end
         ST_SQRT: begin
            if (sqrt_done) begin
               k_in = 2'd0;
               sub_in = 1'b0;
               state_in = ST_UDIV;
            end
         end
         ST_UDIV: begin
            // Rounded unit vector component, sign applied afterward
            if (!sub_ff) begin
               sub_in = 1'b1;
            end else if (div_done) begin
               u_in[k_ff] = d_ff[k_ff][DIR_W-1] ? (COORD_W'(0) - quo_ext) : quo_ext;
               sub_in = 1'b0;
               if (k_ff == 2'd2) begin
                  k_in = 2'd0;
                  state_in = ST_CTRL;
               end else begin
                  k_in = k_ff + 2'd1;
               end
            end
         end
         ST_CTRL: begin
            // Control point: midpoint plus offset, rounded and clamped
            if (!sub_ff) begin
               sub_in = 1'b1;
            end else begin
               m_in[k_ff] = sat_coord(ctrl_acc >>> 30);
               sub_in = 1'b0;
               if (k_ff == 2'd2) begin
                  k_in = 2'd0;
                  state_in = ST_TDIV;
               end else begin
                  k_in = k_ff + 2'd1;
               end
            end
         end
         ST_TDIV: begin
            // Whole and fractional step of t per point
            if (!sub_ff) begin
               sub_in = 1'b1;
            end else if (div_done) begin
               q0_in = div_quo[T_W-1:0];
               r0_in = div_rem[COUNT_W-1:0];
               t_in = '0;
               r_in = {2'b00, nm1_ff};
               i_in = '0;
               j_in = 2'd0;
               sub_in = 1'b0;
               state_in = ST_WGT;
            end
         end
         ST_WGT: begin
            // Bernstein weights (1-t)^2, 2(1-t)t, t^2
            if (!sub_ff) begin
               sub_in = 1'b1;
            end else begin
               w_in[j_ff] = (j_ff == 2'd1) ? (prod_ff[WGT_W-1:0] << 1) : prod_ff[WGT_W-1:0];
               sub_in = 1'b0;
               if (j_ff == 2'd2) begin
                  j_in = 2'd0;
                  k_in = 2'd0;
                  state_in = ST_PNT;
               end else begin
                  j_in = j_ff + 2'd1;
               end
            end
         end
         ST_PNT: begin
            // Accumulate three weighted terms per axis
            if (!sub_ff) begin
               sub_in = 1'b1;
            end else begin
               acc_in = pnt_sum;
               sub_in = 1'b0;
               if (j_ff == 2'd2) begin
                  p_in[k_ff] = sat_coord(pnt_acc >>> 32);
                  j_in = 2'd0;
                  if (k_ff == 2'd2) begin
                     state_in = ST_EMIT;
                  end else begin
                     k_in = k_ff + 2'd1;
                  end
               end else begin
                  j_in = j_ff + 2'd1;
               end
            end
         end
         ST_EMIT: begin
            // Hand the point to the output register, then step t unless it was the last
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {2'b00, i_ff, p_ff[2], p_ff[1], p_ff[0]};
               rsp_last_in = last_pt;
               if (last_pt) begin
                  state_in = ST_IDLE;
               end else begin
                  i_in = i_ff + INDEX_W'(1);
                  if (r_next >= den2) begin
                     r_in = r_next - den2;
                     t_in = t_ff + q0_ff + T_W'(1);
                  end else begin
                     r_in = r_next;
                     t_in = t_ff + q0_ff;
                  end
                  j_in = 2'd0;
                  state_in = ST_WGT;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      s_ff <= s_in;
      e_ff <= e_in;
      m_ff <= m_in;
      u_ff <= u_in;
      p_ff <= p_in;
      d_ff <= d_in;
      w_ff <= w_in;
      h_ff <= h_in;
      nm1_ff <= nm1_in;
      i_ff <= i_in;
      k_ff <= k_in;
      j_ff <= j_in;
      len_ff <= len_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      t_ff <= t_in;
      q0_ff <= q0_in;
      r_ff <= r_in;
      r0_ff <= r0_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         sub_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sub_ff <= sub_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   qba_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sqrt_x),
      .busy     (sqrt_busy),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   qba_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_num),
      .denom (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tlast = rsp_last_ff;

   // A request is taken only with both iterative units at rest
   a_units_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (!sqrt_busy && !div_busy))
      else $error("request accepted while an iterative unit is busy");

   // The stepped t lands exactly on one at the final point
   a_t_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && i_ff == nm1_ff) |-> (t_ff == T_W'(T_ONE)))
      else $error("t does not reach one at the final point");

   // A run keeps going, or holds its last beat, after any beat other than its last
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> (state_ff != ST_IDLE || rsp_tvalid))
      else $error("run ended without a last beat");

endmodule

// ===== sim/tb_quadratic_bezier_arc_points.sv =====
module tb_quadratic_bezier_arc_points;
   timeunit 1ns;
   timeprecision 1ps;
   import qba_pkg::*;

   typedef struct {
      logic signed [COORD_W-1:0] start_x, start_y, start_z;
      logic signed [COORD_W-1:0] end_x, end_y, end_z;
      logic signed [COORD_W-1:0] bend_height;
      logic signed [DIR_W-1:0]   bend_dir_x, bend_dir_y, bend_dir_z;
      logic [COUNT_W-1:0]        point_count;
   } arc_type;

   typedef struct {
      logic signed [COORD_W-1:0] point_x, point_y, point_z;
      logic [INDEX_W-1:0]        point_index;
      logic                      last_point;
   } point_type;

   localparam int DRAIN_CYCLES = 400;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;
   logic               rsp_tlast;

   point_type curve_points_due[$];
   int     fail_count = 0;
   bit     send_steady = 1'b0;
   bit     recv_steady = 1'b0;

   quadratic_bezier_arc_points DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #20ms;
      $display("CHECK FAILED");
      $finish;
   end

   // Integer square root, bit by bit
   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned root;
      longint unsigned one;
      root = 0;
      one = 64'd1 << 62;
      while (one > v) one = one >> 2;
      while (one != 0) begin
         if (v >= root + one) begin
            v = v - (root + one);
            root = (root >> 1) + one;
         end else begin
            root = root >> 1;
         end
         one = one >> 2;
      end
      return root;
   endfunction

   // Round to nearest (ties up) of acc / 2^k, clamp to the coordinate range
   function automatic logic signed [COORD_W-1:0] round_clamp(
      input logic signed [127:0] acc, input int k);
      logic signed [127:0] r;
      r = (acc + (128'sd1 <<< (k - 1))) >>> k;
      if (r > 128'sd2147483647) return 32'sh7fffffff;
      if (r < -128'sd2147483648) return 32'sh80000000;
      return r[COORD_W-1:0];
   endfunction

   // Tessellate one arc into the queue of curve points due
   function automatic void tessellate_arc(input arc_type a);
      longint            d [3];
      longint            u [3];
      logic signed [127:0] s [3];
      logic signed [127:0] e [3];
      logic signed [127:0] m [3];
      logic signed [127:0] h, acc, wa, wb, wc, uk;
      longint unsigned   n, len2, den, mag, q, t, sc;
      bit                tiny;
      point_type         p;
      logic signed [COORD_W-1:0] res [3];
      n = a.point_count;
      if (n > MAX_POINTS) n = MAX_POINTS;
      if (n < 2) return;
      s[0] = a.start_x; s[1] = a.start_y; s[2] = a.start_z;
      e[0] = a.end_x;   e[1] = a.end_y;   e[2] = a.end_z;
      d[0] = a.bend_dir_x; d[1] = a.bend_dir_y; d[2] = a.bend_dir_z;
      h = a.bend_height;
      tiny = 1'b1;
      for (int k = 0; k < 3; k++) if (d[k] > 1 || d[k] < -1) tiny = 1'b0;
      // normalize the direction, straight up when near zero
      if (tiny) begin
         u[0] = 0; u[1] = 0; u[2] = 64'sd1 << 30;
      end else begin
         len2 = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
         den = int_sqrt(len2 << 28);
         for (int k = 0; k < 3; k++) begin
            mag = longint'(d[k] < 0 ? -d[k] : d[k]) << 44;
            q = (mag + den / 2) / den;
            u[k] = d[k] < 0 ? -longint'(q) : longint'(q);
         end
      end
      for (int k = 0; k < 3; k++) begin
         uk = u[k];
         acc = ((s[k] + e[k]) <<< 29) + uk * h;
         m[k] = round_clamp(acc, 30);
      end
      for (longint unsigned i = 0; i < n; i++) begin
         t = (i * 2 * T_ONE + (n - 1)) / (2 * (n - 1));
         sc = T_ONE - t;
         wa = sc * sc;
         wb = 2 * sc * t;
         wc = t * t;
         for (int k = 0; k < 3; k++) begin
            acc = wa * s[k] + wb * m[k] + wc * e[k];
            res[k] = round_clamp(acc, 32);
         end
         p.point_x = res[0];
         p.point_y = res[1];
         p.point_z = res[2];
         p.point_index = i[INDEX_W-1:0];
         p.last_point = (i == n - 1);
         curve_points_due.push_back(p);
      end
   endfunction

   // Drive one arc beat, idling at random before it
   task automatic send_arc(input arc_type a);
      while (!send_steady && $urandom_range(99) < 35) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, a.point_count, a.bend_dir_z, a.bend_dir_y, a.bend_dir_x,
                    a.bend_height, a.end_z, a.end_y, a.end_x,
                    a.start_z, a.start_y, a.start_x};
      do @(posedge clock); while (!req_tready);
      tessellate_arc(a);
   endtask

   // Hold off until every curve point has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (curve_points_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Check each point beat against the oldest expectation
   always @(posedge clock) begin
      point_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (curve_points_due.size() == 0) begin
               $error("unexpected point beat %h", rsp_tdata);
               fail_count++;
            end else begin
               want = curve_points_due.pop_front();
               if (rsp_tdata[31:0] !== want.point_x) begin
                  $error("point_x: expected %0d, got %0d", want.point_x,
                         $signed(rsp_tdata[31:0]));
                  fail_count++;
               end
               if (rsp_tdata[63:32] !== want.point_y) begin
                  $error("point_y: expected %0d, got %0d", want.point_y,
                         $signed(rsp_tdata[63:32]));
                  fail_count++;
               end
               if (rsp_tdata[95:64] !== want.point_z) begin
                  $error("point_z: expected %0d, got %0d", want.point_z,
                         $signed(rsp_tdata[95:64]));
                  fail_count++;
               end
               if (rsp_tdata[101:96] !== want.point_index) begin
                  $error("point_index: expected %0d, got %0d", want.point_index,
                         rsp_tdata[101:96]);
                  fail_count++;
               end
               if (rsp_tlast !== want.last_point) begin
                  $error("last_point: expected %0d, got %0d", want.last_point,
                         rsp_tlast);
                  fail_count++;
               end
            end
         end
         rsp_tready <= recv_steady || ($urandom_range(99) >= 35);
      end
   end

   function automatic logic signed [COORD_W-1:0] pick_coord();
      case ($urandom_range(4))
         0: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         1: return $signed($urandom_range(2097152)) - 32'sd1048576;
         2: return $signed($urandom_range(65536)) - 32'sd32768;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [DIR_W-1:0] pick_dir();
      case ($urandom_range(3))
         0: return $signed(DIR_W'($urandom_range(2))) - 16'sd1;
         1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
         default: return DIR_W'($urandom);
      endcase
   endfunction

   function automatic arc_type pick_arc();
      arc_type a;
      a.start_x = pick_coord(); a.start_y = pick_coord(); a.start_z = pick_coord();
      a.end_x = pick_coord();   a.end_y = pick_coord();   a.end_z = pick_coord();
      a.bend_height = pick_coord();
      a.bend_dir_x = pick_dir(); a.bend_dir_y = pick_dir(); a.bend_dir_z = pick_dir();
      case ($urandom_range(19))
         0: a.point_count = $urandom_range(1);
         1: a.point_count = $urandom_range(127, 40);
         default: a.point_count = $urandom_range(12, 2);
      endcase
      return a;
   endfunction

   function automatic arc_type make_arc(input logic signed [COORD_W-1:0] c,
                                        input logic signed [COORD_W-1:0] ht,
                                        input logic signed [DIR_W-1:0] dx,
                                        input logic signed [DIR_W-1:0] dy,
                                        input logic signed [DIR_W-1:0] dz,
                                        input logic [COUNT_W-1:0] n);
      arc_type a;
      a.start_x = c; a.start_y = -c; a.start_z = c;
      a.end_x = -c;  a.end_y = c;    a.end_z = c;
      a.bend_height = ht;
      a.bend_dir_x = dx; a.bend_dir_y = dy; a.bend_dir_z = dz;
      a.point_count = n;
      return a;
   endfunction

   // Count edges: none, one, two, full, clamped
   task automatic test_point_counts();
      send_arc(make_arc(32'sd256, 32'sd512, 16'sd16384, 0, 0, 7'd0));
      send_arc(make_arc(32'sd256, 32'sd512, 16'sd16384, 0, 0, 7'd1));
      send_arc(make_arc(32'sd256, 32'sd512, 16'sd16384, 0, 0, 7'd2));
      send_arc(make_arc(-32'sd1000, 32'sd700, 0, 16'sd16384, 0, 7'd3));
      send_arc(make_arc(32'sd5000, -32'sd300, 0, 0, 16'sd16384, 7'd64));
      send_arc(make_arc(32'sd77, 32'sd99, 16'sd3, 16'sd4, 0, 7'd65));
      send_arc(make_arc(32'sd12345, -32'sd9999, 16'sd100, -16'sd200, 16'sd300, 7'd127));
      wait_drained();
   endtask

   // Direction edges: near zero, single axis, full scale
   task automatic test_bend_directions();
      send_arc(make_arc(32'sd4096, 32'sd2560, 0, 0, 0, 7'd5));
      send_arc(make_arc(32'sd4096, 32'sd2560, 16'sd1, -16'sd1, 16'sd1, 7'd4));
      send_arc(make_arc(32'sd4096, -32'sd2560, 16'sd2, 0, 0, 7'd4));
      send_arc(make_arc(32'sd4096, 32'sd2560, -16'sd32768, -16'sd32768, -16'sd32768, 7'd6));
      send_arc(make_arc(-32'sd4096, 32'sd2560, 16'sd32767, 16'sd32767, 16'sd32767, 7'd6));
      send_arc(make_arc(32'sd1, 32'sd1, 0, -16'sd32768, 0, 7'd3));
      wait_drained();
   endtask

   // Saturation of the control point and of the curve
   task automatic test_saturation();
      send_arc(make_arc(32'sh7fffffff, 32'sh7fffffff, 16'sd16384, 16'sd16384, 0, 7'd5));
      send_arc(make_arc(32'sh80000000, 32'sh80000000, 16'sd16384, 0, 16'sd16384, 7'd5));
      send_arc(make_arc(32'sh7fffffff, 32'sh80000000, 0, 0, 0, 7'd4));
      send_arc(make_arc(32'sh80000000, 32'sh7fffffff, -16'sd32768, 16'sd32767, 0, 7'd3));
      send_arc(make_arc(0, 32'sh7fffffff, -16'sd7, 16'sd5, -16'sd3, 7'd8));
      wait_drained();
   endtask

   // Random arcs, a stretch with no idling in the middle
   task automatic test_random_arcs(input int count);
      for (int j = 0; j < count; j++) begin
         send_steady = (j >= count / 3 && j < count / 2);
         recv_steady = send_steady;
         send_arc(pick_arc());
      end
      send_steady = 1'b0;
      recv_steady = 1'b0;
      wait_drained();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_point_counts();
      test_bend_directions();
      test_saturation();
      test_random_arcs(90);
      test_random_arcs(90);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
